// ===== design/lcar_pkg.sv =====
package lcar_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAIN_PULSES       = 3'd0;
    localparam logic [2:0] CFG_SAMPLES_PER_READ  = 3'd1;
    localparam logic [2:0] CFG_HALF_PERIOD_TICKS = 3'd2;
    localparam logic [2:0] CFG_TARE_OFFSET       = 3'd3;
    localparam logic [2:0] CFG_SCALE_FACTOR      = 3'd4;

    // Serial frame: data bits per conversion
    localparam int unsigned DATA_BITS = 24;

    // Output beat layout
    localparam int unsigned OUT_BITS = 66;
    localparam int unsigned OUT_TDATA_W = 72;

    // Commands from controller to datapath
    typedef struct packed {
        logic start_clear;   // new measurement: clear index and sum
        logic shift_clear;   // new conversion: clear shift word
        logic shift_in;      // shift in the data pin
        logic store;         // store sample and add to sum
        logic tick_emit;     // load a plain tick beat
        logic tick_sck;
        logic tick_busy;
        logic div_load_avg;  // divide running sum by sample count
        logic div_load_keep; // divide kept sum by kept count
        logic div_step;
        logic set_first;     // latch first average, reset filter
        logic filt_rd;       // read one stored sample
        logic filt_acc;      // test and accumulate that sample
        logic keep_first;    // final average is first average
        logic set_avg_div;   // final average from divider
        logic mul;           // tare and scale product
        logic emit_result;   // load the result beat
    } lcar_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_sample;
        logic div_last;
        logic filt_last;
        logic kept_zero;
        logic out_free;
    } lcar_stat_t;

endpackage

// ===== design/lcar_ctrl.sv =====
module lcar_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              dout_level,
    input  logic              start_req,
    input  logic [1:0]        gain_pulses,
    input  logic [15:0]       half_period_ticks,
    input  lcar_pkg::lcar_stat_t stat,
    output lcar_pkg::lcar_cmd_t  cmd
);
    import lcar_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WAIT,
        ST_BIT_LOW,
        ST_BIT_HIGH,
        ST_GAIN_LOW,
        ST_GAIN_HIGH,
        ST_AVG_LOAD,
        ST_AVG_DIV,
        ST_AVG_SET,
        ST_FILT_RD,
        ST_FILT_ACC,
        ST_KEEP,
        ST_KEEP_DIV,
        ST_KEEP_SET,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] delay_reg, delay_next;
    logic [4:0]  bit_reg, bit_next;
    logic [1:0]  pulse_reg, pulse_next;
    logic        clk_out_reg, clk_out_next;

    logic        serial;
    logic        tick;
    logic        level_done;
    logic        finishing;
    logic [15:0] half;
    logic [1:0]  gain;
    logic [16:0] delay_inc;

    assign half = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
    assign gain = (gain_pulses == 2'd0) ? 2'd1 : gain_pulses;

    assign serial = (state_reg == ST_IDLE) || (state_reg == ST_WAIT) ||
                    (state_reg == ST_BIT_LOW) || (state_reg == ST_BIT_HIGH) ||
                    (state_reg == ST_GAIN_LOW) || (state_reg == ST_GAIN_HIGH);
    assign in_ready = serial && stat.out_free;
    assign tick = in_ready && in_valid;

    assign delay_inc = {1'b0, delay_reg} + 17'd1;
    assign level_done = (delay_inc >= {1'b0, half});

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        delay_next   = delay_reg;
        bit_next     = bit_reg;
        pulse_next   = pulse_reg;
        clk_out_next = clk_out_reg;
        finishing    = 1'b0;
        cmd          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (tick && start_req)
                begin
                    state_next = ST_WAIT;
                    clk_out_next = 1'b0;
                    cmd.start_clear = 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (tick && !dout_level)
                begin
                    state_next = ST_BIT_LOW;
                    delay_next = '0;
                    bit_next = '0;
                    pulse_next = '0;
                    cmd.shift_clear = 1'b1;
                end
            end
            ST_BIT_LOW, ST_GAIN_LOW:
            begin
                if (tick)
                begin
                    delay_next = level_done ? 16'd0 : delay_inc[15:0];
                    if (level_done)
                    begin
                        state_next = (state_reg == ST_BIT_LOW) ? ST_BIT_HIGH : ST_GAIN_HIGH;
                        clk_out_next = 1'b1;
                    end
                end
            end
            ST_BIT_HIGH:
            begin
                if (tick)
                begin
                    delay_next = level_done ? 16'd0 : delay_inc[15:0];
                    if (level_done)
                    begin
                        cmd.shift_in = 1'b1;
                        clk_out_next = 1'b0;
                        bit_next = bit_reg + 5'd1;
                        state_next = (bit_next >= 5'(DATA_BITS)) ? ST_GAIN_LOW : ST_BIT_LOW;
                    end
                end
            end
            ST_GAIN_HIGH:
            begin
                if (tick)
                begin
                    delay_next = level_done ? 16'd0 : delay_inc[15:0];
                    if (level_done)
                    begin
                        clk_out_next = 1'b0;
                        if ({1'b0, pulse_reg} + 3'd1 >= {1'b0, gain})
                        begin
                            cmd.store = 1'b1;
                            pulse_next = '0;
                            if (stat.last_sample)
                            begin
                                finishing = 1'b1;
                                clk_out_next = 1'b1;
                                state_next = ST_AVG_LOAD;
                            end
                            else
                            begin
                                state_next = ST_WAIT;
                            end
                        end
                        else
                        begin
                            pulse_next = pulse_reg + 2'd1;
                            state_next = ST_GAIN_LOW;
                        end
                    end
                end
            end
            ST_AVG_LOAD:
            begin
                cmd.div_load_avg = 1'b1;
                state_next = ST_AVG_DIV;
            end
            ST_AVG_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_AVG_SET;
                end
            end
            ST_AVG_SET:
            begin
                cmd.set_first = 1'b1;
                state_next = ST_FILT_RD;
            end
            ST_FILT_RD:
            begin
                cmd.filt_rd = 1'b1;
                state_next = ST_FILT_ACC;
            end
            ST_FILT_ACC:
            begin
                cmd.filt_acc = 1'b1;
                state_next = stat.filt_last ? ST_KEEP : ST_FILT_RD;
            end
            ST_KEEP:
            begin
                if (stat.kept_zero)
                begin
                    cmd.keep_first = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    cmd.div_load_keep = 1'b1;
                    state_next = ST_KEEP_DIV;
                end
            end
            ST_KEEP_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_KEEP_SET;
                end
            end
            ST_KEEP_SET:
            begin
                cmd.set_avg_div = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                clk_out_next = 1'b1;
            end
        endcase

        // Every plain tick yields one beat
        if (tick && !finishing)
        begin
            cmd.tick_emit = 1'b1;
            cmd.tick_sck = clk_out_next;
            cmd.tick_busy = (state_next != ST_IDLE);
        end
    end

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            delay_reg   <= '0;
            bit_reg     <= '0;
            pulse_reg   <= '0;
            clk_out_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            delay_reg   <= delay_next;
            bit_reg     <= bit_next;
            pulse_reg   <= pulse_next;
            clk_out_reg <= clk_out_next;
        end
    end

endmodule

// ===== design/lcar_dp.sv =====
module lcar_dp
#(
    parameter int unsigned MAX_SAMPLES = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       dout_level,
    input  logic [6:0]                 samples_per_read,
    input  logic signed [23:0]         tare_offset,
    input  logic signed [31:0]         scale_factor,
    input  lcar_pkg::lcar_cmd_t        cmd,
    output lcar_pkg::lcar_stat_t       stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lcar_pkg::OUT_BITS-1:0] out_data
);
    import lcar_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned SUM_W  = DATA_BITS + CNT_W;
    localparam int unsigned DCNT_W = $clog2(SUM_W + 1);
    localparam int unsigned TW     = 10;

    logic [23:0]             shift_reg;
    logic [23:0]             mem [MAX_SAMPLES];
    logic [23:0]             rd_data_reg;
    logic [CNT_W-1:0]        index_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [ADDR_W-1:0]       filt_idx_reg;
    logic signed [SUM_W-1:0] ksum_reg;
    logic [CNT_W-1:0]        kcnt_reg;
    logic signed [23:0]      first_reg;
    logic signed [23:0]      avg_reg;
    logic signed [56:0]      prod_reg;

    // Divider registers
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        dvs_reg;
    logic                    neg_reg;
    logic [DCNT_W-1:0]       dcnt_reg;

    logic                    out_valid_reg;
    logic [OUT_BITS-1:0]     out_data_reg;

    // Target count, clamped to the store depth
    logic [TW-1:0] target;
    logic [TW-1:0] spr_ext;
    assign spr_ext = (samples_per_read == 7'd0) ? TW'(1) : TW'(samples_per_read);
    assign target = (spr_ext > TW'(MAX_SAMPLES)) ? TW'(MAX_SAMPLES) : spr_ext;

    // Divider step
    logic [CNT_W:0]       trial;
    logic                 qbit;
    logic [SUM_W-1:0]     quo_signed;
    logic signed [23:0]   div_res;
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign qbit = (trial >= {1'b0, dvs_reg});
    assign quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign div_res = quo_signed[23:0];

    logic [SUM_W-1:0] sum_mag;
    logic [SUM_W-1:0] ksum_mag;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign ksum_mag = ksum_reg[SUM_W-1] ? SUM_W'(-ksum_reg) : SUM_W'(ksum_reg);

    // Outlier test: keep when 4*|s - avg| <= |avg|
    logic signed [24:0] diff;
    logic [24:0]        abs_diff;
    logic [23:0]        abs_first;
    logic               keep;
    assign diff = {rd_data_reg[23], rd_data_reg} - {first_reg[23], first_reg};
    assign abs_diff = diff[24] ? 25'(-diff) : 25'(diff);
    assign abs_first = first_reg[23] ? 24'(-first_reg) : 24'(first_reg);
    assign keep = ({abs_diff, 2'b00} <= {3'b000, abs_first});

    // Tare and saturate
    logic signed [24:0] tared;
    logic signed [32:0] mass_wide;
    logic [31:0]        mass;
    assign tared = {avg_reg[23], avg_reg} - {tare_offset[23], tare_offset};
    assign mass_wide = prod_reg[56:24];
    always_comb
    begin
        if (mass_wide[32] != mass_wide[31])
        begin
            mass = mass_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            mass = mass_wide[31:0];
        end
    end

    logic [TW-1:0] index_inc;
    assign index_inc = TW'(index_reg) + TW'(1);

    assign stat.last_sample = (index_inc >= target);
    assign stat.div_last = (dcnt_reg == DCNT_W'(1));
    assign stat.filt_last = ((TW'(filt_idx_reg) + TW'(1)) >= TW'(index_reg));
    assign stat.kept_zero = (kcnt_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    // Sample store and read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[index_reg[ADDR_W-1:0]] <= shift_reg;
        end
        if (cmd.filt_rd)
        begin
            rd_data_reg <= mem[filt_idx_reg];
        end
    end

    // Acquisition, filter and arithmetic registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            index_reg    <= '0;
            sum_reg      <= '0;
            filt_idx_reg <= '0;
            ksum_reg     <= '0;
            kcnt_reg     <= '0;
            first_reg    <= '0;
            avg_reg      <= '0;
            prod_reg     <= '0;
            quo_reg      <= '0;
            rem_reg      <= '0;
            dvs_reg      <= '0;
            neg_reg      <= 1'b0;
            dcnt_reg     <= '0;
        end
        else
        begin
            if (cmd.start_clear)
            begin
                index_reg <= '0;
                sum_reg <= '0;
                kcnt_reg <= '0;
            end
            if (cmd.shift_clear)
            begin
                shift_reg <= '0;
            end
            if (cmd.shift_in)
            begin
                shift_reg <= {shift_reg[22:0], dout_level};
            end
            if (cmd.store)
            begin
                sum_reg <= sum_reg + {{(SUM_W-DATA_BITS){shift_reg[23]}}, shift_reg};
                index_reg <= index_reg + CNT_W'(1);
            end
            // Load the shared divider
            if (cmd.div_load_avg)
            begin
                quo_reg <= sum_mag;
                rem_reg <= '0;
                dvs_reg <= index_reg;
                neg_reg <= sum_reg[SUM_W-1];
                dcnt_reg <= DCNT_W'(SUM_W);
            end
            if (cmd.div_load_keep)
            begin
                quo_reg <= ksum_mag;
                rem_reg <= '0;
                dvs_reg <= kcnt_reg;
                neg_reg <= ksum_reg[SUM_W-1];
                dcnt_reg <= DCNT_W'(SUM_W);
            end
            // One quotient bit per cycle
            if (cmd.div_step)
            begin
                rem_reg <= qbit ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], qbit};
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
            if (cmd.set_first)
            begin
                first_reg <= div_res;
                filt_idx_reg <= '0;
                ksum_reg <= '0;
                kcnt_reg <= '0;
            end
            if (cmd.filt_acc)
            begin
                if (keep)
                begin
                    ksum_reg <= ksum_reg + {{(SUM_W-DATA_BITS){rd_data_reg[23]}}, rd_data_reg};
                    kcnt_reg <= kcnt_reg + CNT_W'(1);
                end
                filt_idx_reg <= filt_idx_reg + ADDR_W'(1);
            end
            if (cmd.keep_first)
            begin
                avg_reg <= first_reg;
            end
            if (cmd.set_avg_div)
            begin
                avg_reg <= div_res;
            end
            if (cmd.mul)
            begin
                prod_reg <= tared * scale_factor;
            end
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.tick_emit || cmd.emit_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_emit)
        begin
            out_data_reg <= {7'd0, 32'd0, 24'd0, 1'b0, cmd.tick_busy, cmd.tick_sck};
        end
        else if (cmd.emit_result)
        begin
            out_data_reg <= {7'(kcnt_reg), mass, avg_reg, 1'b1, 1'b0, 1'b1};
        end
    end

endmodule

// ===== design/load_cell_adc_reader_unit.sv =====
// Load cell converter reader.
// Input stream: one beat per pin tick, tdata bit 0 is the converter data pin,
// bit 1 a start request. Output stream: one beat per input beat, carrying the
// serial clock level, busy flag and, on the final beat of a measurement, the
// filtered raw average, tared and scaled mass and number of samples kept.
// A plain tick leaves through a single output register, so one beat per
// cycle flows while the receiver takes beats.
// The tick that stores the last sample starts the arithmetic: a shared
// one-bit-per-cycle divider for the first average, the outlier filter over
// the sample memory, the divider again for the kept average (the first
// average stands if none is kept), a multiply and a load of the result,
// during which input is not accepted.
// A stalled receiver holds the output register and so stops input.
// Reset returns to idle with the serial clock high (converter powered down)
// and loads the register defaults; the sample memory needs no clearing.
// Configuration is written through cfg_we / cfg_index / cfg_data.
module load_cell_adc_reader_unit
#(
    parameter int unsigned MAX_SAMPLES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] dout_level, [1] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [lcar_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [0] sck_level,
                        // [1] busy_res, [2] result_valid, [26:3] raw_average,
                        // [58:27] mass, [65:59] samples_kept
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lcar_pkg::*;

    logic [1:0]         gain_reg;
    logic [6:0]         spr_reg;
    logic [15:0]        half_reg;
    logic signed [23:0] tare_reg;
    logic signed [31:0] scale_reg;

    lcar_cmd_t           cmd;
    lcar_stat_t          stat;
    logic [OUT_BITS-1:0] out_bits;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 2'd1;
            spr_reg   <= 7'd8;
            half_reg  <= 16'd1;
            tare_reg  <= '0;
            scale_reg <= 32'sd16777216;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_PULSES:       gain_reg  <= cfg_data[1:0];
                CFG_SAMPLES_PER_READ:  spr_reg   <= cfg_data[6:0];
                CFG_HALF_PERIOD_TICKS: half_reg  <= cfg_data[15:0];
                CFG_TARE_OFFSET:       tare_reg  <= cfg_data[23:0];
                CFG_SCALE_FACTOR:      scale_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    lcar_ctrl u_ctrl
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .dout_level        (s_axis_tdata[0]),
        .start_req         (s_axis_tdata[1]),
        .gain_pulses       (gain_reg),
        .half_period_ticks (half_reg),
        .stat              (stat),
        .cmd               (cmd)
    );

    lcar_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .dout_level       (s_axis_tdata[0]),
        .samples_per_read (spr_reg),
        .tare_offset      (tare_reg),
        .scale_factor     (scale_reg),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_data         (out_bits)
    );

    // Pad the beat to whole bytes
    assign m_axis_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_bits};

endmodule
